@@ design/cyk_derivation_counter_assert.svh @@
// assertion macros used by the port-level checker
`ifndef CYK_DERIVATION_COUNTER_ASSERT_SVH
`define CYK_DERIVATION_COUNTER_ASSERT_SVH

// same-cycle implication, sampled on clk, idle during reset
`define CYK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CYK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cyk_pkg.sv @@
// shared constants, codes and helpers of the derivation counter
package cyk_pkg;

  localparam int MAX_WORD   = 32;
  localparam int MAX_RULES  = 64;
  localparam int NUM_NT     = 26;
  localparam int WORD_AW    = $clog2(MAX_WORD);
  localparam int LEN_W      = $clog2(MAX_WORD + 1);
  localparam int RULE_AW    = $clog2(MAX_RULES);
  localparam int RCNT_W     = $clog2(MAX_RULES + 1);
  localparam int NT_W       = 5;
  localparam int SYM_W      = 8;
  localparam int OP_W       = 3;
  localparam int ST_W       = 2;
  localparam int CNT_W      = 30;
  localparam int TRULE_W    = NT_W + SYM_W;
  localparam int BRULE_W    = 3 * NT_W;
  localparam int SPAN_AW    = NT_W + 2 * WORD_AW;
  localparam int SPAN_DEPTH = NUM_NT << (2 * WORD_AW);

  localparam logic [CNT_W-1:0] PRIME = CNT_W'(1000000007);

  typedef enum logic [OP_W-1:0] {
    OP_TERM   = 3'd0,
    OP_BINARY = 3'd1,
    OP_APPEND = 3'd2,
    OP_RUN    = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // sum of two residues, reduced once
  function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
    return s[CNT_W-1:0];
  endfunction

endpackage

@@ design/cyk_ram.sv @@
// generic single-write single-read synchronous ram
module cyk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ design/cyk_mulmod.sv @@
// bit-serial modular multiplier, one multiplier bit per cycle
module cyk_mulmod import cyk_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [CNT_W-1:0] x,
  input  logic [CNT_W-1:0] y,
  output logic             done,
  output logic [CNT_W-1:0] prod
);

  localparam int BIT_W = $clog2(CNT_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BIT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] x_r, x_nxt;
  logic [CNT_W-1:0] y_r, y_nxt;
  logic [CNT_W-1:0] p_r, p_nxt;
  logic [CNT_W:0]   dbl;
  logic [CNT_W:0]   dbl_red;

  always_comb begin
    dbl = {p_r, 1'b0};
    if (dbl >= {1'b0, PRIME}) dbl_red = dbl - {1'b0, PRIME};
    else dbl_red = dbl;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = BIT_W'(CNT_W - 1);
      x_nxt    = x;
      y_nxt    = y;
      p_nxt    = '0;
    end else if (busy_r) begin
      // msb first: p = 2p + bit*x, kept below the prime
      p_nxt = y_r[CNT_W-1] ? add_mod(dbl_red[CNT_W-1:0], x_r) : dbl_red[CNT_W-1:0];
      y_nxt = {y_r[CNT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

@@ design/cyk_derivation_counter.sv @@
// CYK derivation counter: counts parses of a stored word modulo 1000000007
// Usage: one transaction in on in_valid/in_stall, one result out on out_valid/out_stall.
// Terminal rule, binary rule, append, clear and unused opcodes finish in the
// accept cycle; their result shows in the output register in the next cycle.
// A load beyond capacity is dropped with status 1. Compute on an empty word
// gives status 2 at once.
// Compute walks the span table held in one synchronous ram. For a word of n
// characters it checks each terminal rule per character and each binary rule
// per split point of every span of width 2 or more, writes the 26 entries of
// each span and ends in the done state; a binary rule naming an unused
// nonterminal skips the multiply. The 30-step bit-serial modular multiplier
// runs once per binary rule and split point. No other transaction is taken
// meanwhile.
// Every table entry read is written earlier in the same compute, so the
// table needs no clearing pass.
// Reset (rst_n low, synchronous) empties the word and both rule stores.
// in_stall is high while a compute runs, and while an undelivered result is
// held and out_stall is high; a stalled result holds its value.
module cyk_derivation_counter import cyk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [NT_W-1:0]   in_lhs,
  input  logic [NT_W-1:0]   in_first_rhs,
  input  logic [NT_W-1:0]   in_second_rhs,
  input  logic [SYM_W-1:0]  in_symbol,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  out_count,
  output logic [ST_W-1:0]   out_status
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LWRD  = 10'b0000000010,
    S_LRULE = 10'b0000000100,
    S_LCHK  = 10'b0000001000,
    S_BRULE = 10'b0000010000,
    S_BSPAN = 10'b0000100000,
    S_BLOAD = 10'b0001000000,
    S_BMUL  = 10'b0010000000,
    S_WRITE = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [RCNT_W-1:0] tcnt_r, tcnt_nxt;
  logic [RCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [NT_W-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]  w_r, w_nxt;
  logic [WORD_AW-1:0] i_r, i_nxt;
  logic [WORD_AW-1:0] mid_r, mid_nxt;
  logic [RCNT_W-1:0] r_r, r_nxt;
  logic [NT_W-1:0]   k_r, k_nxt;
  logic [NT_W-1:0]   a_r, a_nxt;
  logic [CNT_W-1:0]  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  logic [CNT_W-1:0]  acc_r [NUM_NT];
  logic [NT_W-1:0]   acc_idx;
  logic [CNT_W-1:0]  acc_rd;
  logic              acc_we;
  logic [CNT_W-1:0]  acc_wdata;

  logic [CNT_W-1:0]  span_mem [SPAN_DEPTH];
  logic              span_we, span_re;
  logic [SPAN_AW-1:0] span_waddr, span_raddr0, span_raddr1;
  logic [CNT_W-1:0]  span_rd0, span_rd1;

  logic              word_we, word_re;
  logic [SYM_W-1:0]  word_rdata;
  logic              trule_we, trule_re;
  logic [TRULE_W-1:0] trule_rdata;
  logic              brule_we, brule_re;
  logic [BRULE_W-1:0] brule_rdata;

  logic              mul_start, mul_done;
  logic [CNT_W-1:0]  mul_prod;

  logic              in_acc;
  logic [LEN_W:0]    j_ext;
  logic [WORD_AW-1:0] j;
  logic [WORD_AW-1:0] mid_inc;
  logic              adv_rule;
  logic [NT_W-1:0]   t_nt, b_a, b_b, b_c;
  logic [SYM_W-1:0]  t_ch;
  logic              last_of_width;
  logic [LEN_W-1:0]  w_next_span;
  logic [WORD_AW-1:0] i_next_span;

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign j_ext   = {1'b0, i_r} + {1'b0, w_r} - 1'b1;
  assign j       = j_ext[WORD_AW-1:0];
  assign mid_inc = mid_r + 1'b1;
  assign t_nt    = trule_rdata[TRULE_W-1:SYM_W];
  assign t_ch    = trule_rdata[SYM_W-1:0];
  assign b_a     = brule_rdata[3*NT_W-1:2*NT_W];
  assign b_b     = brule_rdata[2*NT_W-1:NT_W];
  assign b_c     = brule_rdata[NT_W-1:0];
  assign last_of_width = (({1'b0, i_r} + {1'b0, w_r}) == {1'b0, len_r});

  always_comb begin
    case (state_r)
      S_LCHK:  acc_idx = t_nt;
      S_BMUL:  acc_idx = a_r;
      default: acc_idx = k_r;
    endcase
  end
  assign acc_rd = acc_r[acc_idx];

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    tcnt_nxt       = tcnt_r;
    bcnt_nxt       = bcnt_r;
    start_nxt      = start_r;
    w_nxt          = w_r;
    i_nxt          = i_r;
    mid_nxt        = mid_r;
    r_nxt          = r_r;
    k_nxt          = k_r;
    a_nxt          = a_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    acc_we         = 1'b0;
    acc_wdata      = '0;
    span_we        = 1'b0;
    span_re        = 1'b0;
    span_waddr     = {k_r, i_r, j};
    span_raddr0    = {b_b, i_r, mid_r};
    span_raddr1    = {b_c, mid_inc, j};
    word_we        = 1'b0;
    word_re        = 1'b0;
    trule_we       = 1'b0;
    trule_re       = 1'b0;
    brule_we       = 1'b0;
    brule_re       = 1'b0;
    mul_start      = 1'b0;
    adv_rule       = 1'b0;
    w_next_span    = w_r;
    i_next_span    = i_r + 1'b1;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = '0;
          out_status_nxt = ST_OK;
          case (in_opcode)
            OP_TERM: begin
              if (tcnt_r < RCNT_W'(MAX_RULES)) begin
                trule_we = 1'b1;
                tcnt_nxt = tcnt_r + 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_BINARY: begin
              if (bcnt_r < RCNT_W'(MAX_RULES)) begin
                brule_we = 1'b1;
                bcnt_nxt = bcnt_r + 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_APPEND: begin
              if (len_r < LEN_W'(MAX_WORD)) begin
                word_we = 1'b1;
                len_nxt = len_r + 1'b1;
              end else begin
                out_status_nxt = ST_FULL;
              end
            end
            OP_RUN: begin
              if (len_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // result goes out from the done state instead
                out_valid_nxt = 1'b0;
                start_nxt     = in_lhs;
                res_nxt       = '0;
                w_nxt         = LEN_W'(1);
                i_nxt         = '0;
                state_nxt     = S_LWRD;
              end
            end
            OP_CLEAR: begin
              len_nxt  = '0;
              tcnt_nxt = '0;
              bcnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_LWRD: begin
        word_re = 1'b1;
        r_nxt   = '0;
        k_nxt   = '0;
        state_nxt = (tcnt_r == '0) ? S_WRITE : S_LRULE;
      end
      S_LRULE: begin
        trule_re  = 1'b1;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (t_nt < NT_W'(NUM_NT) && t_ch == word_rdata) begin
          acc_we    = 1'b1;
          acc_wdata = add_mod(acc_rd, CNT_W'(1));
        end
        r_nxt = r_r + 1'b1;
        if (r_r + 1'b1 == tcnt_r) begin
          k_nxt     = '0;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_LRULE;
        end
      end
      S_BRULE: begin
        brule_re  = 1'b1;
        state_nxt = S_BSPAN;
      end
      S_BSPAN: begin
        if (b_a < NT_W'(NUM_NT) && b_b < NT_W'(NUM_NT) && b_c < NT_W'(NUM_NT)) begin
          span_re   = 1'b1;
          a_nxt     = b_a;
          state_nxt = S_BLOAD;
        end else begin
          adv_rule = 1'b1;
        end
      end
      S_BLOAD: begin
        mul_start = 1'b1;
        state_nxt = S_BMUL;
      end
      S_BMUL: begin
        if (mul_done) begin
          acc_we    = 1'b1;
          acc_wdata = add_mod(acc_rd, mul_prod);
          adv_rule  = 1'b1;
        end
      end
      S_WRITE: begin
        span_we   = 1'b1;
        acc_we    = 1'b1;
        acc_wdata = '0;
        if (k_r == start_r) res_nxt = acc_rd;
        k_nxt = k_r + 1'b1;
        if (k_r == NT_W'(NUM_NT - 1)) begin
          k_nxt = '0;
          if (last_of_width) begin
            w_next_span = w_r + 1'b1;
            i_next_span = '0;
          end
          if (last_of_width && w_r == len_r) begin
            state_nxt = S_DONE;
          end else begin
            w_nxt   = w_next_span;
            i_nxt   = i_next_span;
            mid_nxt = i_next_span;
            r_nxt   = '0;
            if (w_next_span == LEN_W'(1)) state_nxt = S_LWRD;
            else if (bcnt_r == '0) state_nxt = S_WRITE;
            else state_nxt = S_BRULE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_count_nxt  = res_r;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // next binary rule, then next split point, then write the span out
    if (adv_rule) begin
      if (r_r + 1'b1 == bcnt_r) begin
        r_nxt   = '0;
        mid_nxt = mid_inc;
        if (mid_inc == j) begin
          k_nxt     = '0;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_BRULE;
        end
      end else begin
        r_nxt     = r_r + 1'b1;
        state_nxt = S_BRULE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      tcnt_r      <= '0;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int n = 0; n < NUM_NT; n++) acc_r[n] <= '0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      tcnt_r      <= tcnt_nxt;
      bcnt_r      <= bcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (acc_we) acc_r[acc_idx] <= acc_wdata;
    end
    start_r      <= start_nxt;
    w_r          <= w_nxt;
    i_r          <= i_nxt;
    mid_r        <= mid_nxt;
    r_r          <= r_nxt;
    k_r          <= k_nxt;
    a_r          <= a_nxt;
    res_r        <= res_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // span table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (span_we) span_mem[span_waddr] <= acc_rd;
    if (span_re) begin
      span_rd0 <= span_mem[span_raddr0];
      span_rd1 <= span_mem[span_raddr1];
    end
  end

  cyk_ram #(.DEPTH(MAX_WORD), .WIDTH(SYM_W)) u_word (
    .clk   (clk),
    .we    (word_we),
    .waddr (len_r[WORD_AW-1:0]),
    .wdata (in_symbol),
    .re    (word_re),
    .raddr (i_r),
    .rdata (word_rdata)
  );

  cyk_ram #(.DEPTH(MAX_RULES), .WIDTH(TRULE_W)) u_trule (
    .clk   (clk),
    .we    (trule_we),
    .waddr (tcnt_r[RULE_AW-1:0]),
    .wdata ({in_lhs, in_symbol}),
    .re    (trule_re),
    .raddr (r_r[RULE_AW-1:0]),
    .rdata (trule_rdata)
  );

  cyk_ram #(.DEPTH(MAX_RULES), .WIDTH(BRULE_W)) u_brule (
    .clk   (clk),
    .we    (brule_we),
    .waddr (bcnt_r[RULE_AW-1:0]),
    .wdata ({in_lhs, in_first_rhs, in_second_rhs}),
    .re    (brule_re),
    .raddr (r_r[RULE_AW-1:0]),
    .rdata (brule_rdata)
  );

  cyk_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (span_rd0),
    .y     (span_rd1),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign out_valid  = out_valid_r;
  assign out_count  = out_count_r;
  assign out_status = out_status_r;

endmodule

@@ design/cyk_checker.sv @@
// port-level checker for the derivation counter, bound to the top level
`include "cyk_derivation_counter_assert.svh"

module cyk_checker import cyk_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic [OP_W-1:0]  in_opcode,
  input logic [NT_W-1:0]  in_lhs,
  input logic [NT_W-1:0]  in_first_rhs,
  input logic [NT_W-1:0]  in_second_rhs,
  input logic [SYM_W-1:0] in_symbol,
  input logic             out_valid,
  input logic             out_stall,
  input logic [CNT_W-1:0] out_count,
  input logic [ST_W-1:0]  out_status
);

  `CYK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `CYK_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_count) && $stable(out_status), "stalled result changed")
  `CYK_ASSERT_NOW(a_count_range, out_valid, out_count < PRIME, "count not reduced")
  `CYK_ASSERT_NOW(a_fail_zero, out_valid && out_status != ST_OK, out_count == '0, "count on failed transaction")
  `CYK_ASSERT_NEXT(a_load_result, in_valid && !in_stall && in_opcode != OP_RUN, out_valid, "load transaction gave no result")

endmodule

bind cyk_derivation_counter cyk_checker u_cyk_checker (.*);

@@ dv/cyk_derivation_counter_tb.sv @@
// testbench of the cyk derivation counter: directed table, random grammars, self-checking
`timescale 1ns / 1ps

module cyk_derivation_counter_tb;
  import cyk_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam longint MODULUS = 64'd1000000007;
  localparam int RANDOM_ITEMS = 1100;
  localparam int IDLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
  } result_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [NT_W-1:0]  lhs;
    logic [NT_W-1:0]  r1;
    logic [NT_W-1:0]  r2;
    logic [SYM_W-1:0] sym;
    bit               typed;
    logic [CNT_W-1:0] count;
    logic [ST_W-1:0]  status;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [OP_W-1:0]  in_opcode;
  logic [NT_W-1:0]  in_lhs;
  logic [NT_W-1:0]  in_first_rhs;
  logic [NT_W-1:0]  in_second_rhs;
  logic [SYM_W-1:0] in_symbol;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [CNT_W-1:0] out_count;
  logic [ST_W-1:0]  out_status;

  cyk_derivation_counter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_lhs(in_lhs), .in_first_rhs(in_first_rhs),
    .in_second_rhs(in_second_rhs), .in_symbol(in_symbol),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_count(out_count), .out_status(out_status)
  );

  // local copy of the grammar and word
  logic [SYM_W-1:0] word_chars [MAX_WORD];
  int               word_len;
  logic [NT_W-1:0]  term_nt [MAX_RULES];
  logic [SYM_W-1:0] term_sym [MAX_RULES];
  int               term_cnt;
  logic [NT_W-1:0]  bin_a [MAX_RULES];
  logic [NT_W-1:0]  bin_b [MAX_RULES];
  logic [NT_W-1:0]  bin_c [MAX_RULES];
  int               bin_cnt;
  logic [CNT_W-1:0] span_tab [NUM_NT][MAX_WORD][MAX_WORD];

  result_t pending_results[$];
  int  err_cnt;
  int  items_sent;
  int  burst_left;
  int  n_runs, n_nonzero, n_full, n_empty;
  int  idle_cycles = 0;
  int  stall_phase = 0;
  int  stall_mode = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
  endtask

  function automatic logic [CNT_W-1:0] count_parses(input logic [NT_W-1:0] start);
    longint prod;
    int j;
    for (int a = 0; a < NUM_NT; a++)
      for (int i = 0; i < MAX_WORD; i++)
        for (int k = 0; k < MAX_WORD; k++) span_tab[a][i][k] = '0;
    for (int i = 0; i < word_len; i++)
      for (int r = 0; r < term_cnt; r++)
        if (term_nt[r] < NUM_NT && term_sym[r] == word_chars[i])
          span_tab[term_nt[r]][i][i] = CNT_W'((longint'(span_tab[term_nt[r]][i][i]) + 1) % MODULUS);
    for (int w = 2; w <= word_len; w++)
      for (int i = 0; i + w <= word_len; i++) begin
        j = i + w - 1;
        for (int m = i; m < j; m++)
          for (int r = 0; r < bin_cnt; r++) begin
            if (bin_a[r] >= NUM_NT || bin_b[r] >= NUM_NT || bin_c[r] >= NUM_NT) continue;
            prod = longint'(span_tab[bin_b[r]][i][m]) * longint'(span_tab[bin_c[r]][m+1][j]);
            span_tab[bin_a[r]][i][j] =
              CNT_W'((longint'(span_tab[bin_a[r]][i][j]) + prod % MODULUS) % MODULUS);
          end
      end
    if (start >= NUM_NT) return '0;
    return span_tab[start][0][word_len-1];
  endfunction

  function automatic result_t apply_item(input logic [OP_W-1:0] op, input logic [NT_W-1:0] lhs,
                                         input logic [NT_W-1:0] r1, input logic [NT_W-1:0] r2,
                                         input logic [SYM_W-1:0] sym);
    result_t res;
    res = '{count: '0, status: ST_OK};
    case (op)
      OP_TERM: begin
        if (term_cnt < MAX_RULES) begin
          term_nt[term_cnt] = lhs;
          term_sym[term_cnt] = sym;
          term_cnt++;
        end else res.status = ST_FULL;
      end
      OP_BINARY: begin
        if (bin_cnt < MAX_RULES) begin
          bin_a[bin_cnt] = lhs;
          bin_b[bin_cnt] = r1;
          bin_c[bin_cnt] = r2;
          bin_cnt++;
        end else res.status = ST_FULL;
      end
      OP_APPEND: begin
        if (word_len < MAX_WORD) begin
          word_chars[word_len] = sym;
          word_len++;
        end else res.status = ST_FULL;
      end
      OP_RUN: begin
        if (word_len == 0) res.status = ST_EMPTY;
        else res.count = count_parses(lhs);
      end
      OP_CLEAR: begin
        word_len = 0;
        term_cnt = 0;
        bin_cnt = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic drive_item(input logic [OP_W-1:0] op, input logic [NT_W-1:0] lhs,
                            input logic [NT_W-1:0] r1, input logic [NT_W-1:0] r2,
                            input logic [SYM_W-1:0] sym, input bit typed,
                            input logic [CNT_W-1:0] t_count, input logic [ST_W-1:0] t_status);
    result_t res;
    int gap;
    @(negedge clk);
    in_opcode = op;
    in_lhs = lhs;
    in_first_rhs = r1;
    in_second_rhs = r2;
    in_symbol = sym;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    res = apply_item(op, lhs, r1, r2, sym);
    if (op == OP_RUN) begin
      n_runs++;
      if (res.count != 0) n_nonzero++;
    end
    if (res.status == ST_FULL) n_full++;
    if (res.status == ST_EMPTY) n_empty++;
    if (typed) res = '{count: t_count, status: t_status};
    pending_results.insert(pending_results.size(), res);
    if (op <= OP_CLEAR) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push(input logic [OP_W-1:0] op, input logic [NT_W-1:0] lhs,
                      input logic [NT_W-1:0] r1, input logic [NT_W-1:0] r2,
                      input logic [SYM_W-1:0] sym);
    drive_item(op, lhs, r1, r2, sym, 1'b0, '0, ST_OK);
  endtask

  function automatic logic [NT_W-1:0] pick_nt();
    if ($urandom_range(0, 9) == 0) return NT_W'($urandom_range(0, 31));
    return NT_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 9) == 0) return SYM_W'($urandom_range(0, 255));
    return SYM_W'(8'h61 + $urandom_range(0, 1));
  endfunction

  // random-content load with an occasional ignored opcode slipped in
  task automatic push_rand(input logic [OP_W-1:0] op, input logic [NT_W-1:0] lhs);
    if ($urandom_range(0, 11) == 0)
      push(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), NT_W'($urandom),
           NT_W'($urandom), NT_W'($urandom), SYM_W'($urandom));
    push(op, lhs, pick_nt(), pick_nt(), pick_sym());
  endtask

  task automatic run_grammar();
    int t_n, b_n, w_n, c_n;
    t_n = $urandom_range(1, 6);
    b_n = $urandom_range(0, 6);
    w_n = $urandom_range(0, 7);
    c_n = $urandom_range(1, 2);
    push_rand(OP_CLEAR, pick_nt());
    for (int k = 0; k < t_n; k++) push_rand(OP_TERM, pick_nt());
    for (int k = 0; k < b_n; k++) push_rand(OP_BINARY, pick_nt());
    for (int k = 0; k < w_n; k++) push_rand(OP_APPEND, pick_nt());
    for (int k = 0; k < c_n; k++) push_rand(OP_RUN, pick_nt());
  endtask

  // fill every store past capacity, compute on a two-character word only
  task automatic run_overflow();
    push(OP_CLEAR, '0, '0, '0, '0);
    for (int k = 0; k <= MAX_RULES; k++) push(OP_TERM, pick_nt(), pick_nt(), pick_nt(), pick_sym());
    for (int k = 0; k <= MAX_RULES; k++) push(OP_BINARY, pick_nt(), pick_nt(), pick_nt(), pick_sym());
    for (int k = 0; k < 2; k++) push(OP_APPEND, pick_nt(), '0, '0, pick_sym());
    push(OP_RUN, NT_W'($urandom_range(0, 3)), '0, '0, '0);
    for (int k = 2; k <= MAX_WORD; k++) push(OP_APPEND, '0, '0, '0, pick_sym());
    push(OP_CLEAR, '0, '0, '0, '0);
  endtask

  row_t directed[] = '{
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_EMPTY},
    '{OP_APPEND, 5'd0,  5'd0,  5'd0,  8'h61, 1'b1, 30'd0, ST_OK},
    '{OP_TERM,   5'd0,  5'd0,  5'd0,  8'h61, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd1, ST_OK},
    '{OP_RUN,    5'd31, 5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd25, 5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_TERM,   5'd0,  5'd0,  5'd0,  8'h61, 1'b0, 30'd0, ST_OK},
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 30'd0, ST_OK},
    '{OP_BINARY, 5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_APPEND, 5'd0,  5'd0,  5'd0,  8'h61, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 30'd0, ST_OK},
    '{OP_BINARY, 5'd31, 5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_BINARY, 5'd0,  5'd31, 5'd31, 8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_TERM,   5'd31, 5'd0,  5'd0,  8'hff, 1'b1, 30'd0, ST_OK},
    '{OP_APPEND, 5'd0,  5'd0,  5'd0,  8'hff, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b0, 30'd0, ST_OK},
    '{OP_SPARE_LO, 5'd0, 5'd0, 5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_SPARE_HI, 5'd31, 5'd31, 5'd31, 8'hff, 1'b1, 30'd0, ST_OK},
    '{OP_CLEAR,  5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_EMPTY},
    '{OP_TERM,   5'd25, 5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_APPEND, 5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd25, 5'd0,  5'd0,  8'h00, 1'b1, 30'd1, ST_OK},
    '{OP_BINARY, 5'd25, 5'd25, 5'd25, 8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_APPEND, 5'd0,  5'd0,  5'd0,  8'h00, 1'b1, 30'd0, ST_OK},
    '{OP_RUN,    5'd25, 5'd0,  5'd0,  8'h00, 1'b0, 30'd0, ST_OK}
  };

  // result channel stall: the pattern is redrawn periodically from four modes
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase % 8 < 3);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, status", -1, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) report_mismatch("status", want.status, out_status);
        if (out_count !== want.count) report_mismatch("count", want.count, out_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_CLEAR;
    in_lhs = '0;
    in_first_rhs = '0;
    in_second_rhs = '0;
    in_symbol = '0;
    err_cnt = 0;
    items_sent = 0;
    burst_left = 4;
    n_runs = 0;
    n_nonzero = 0;
    n_full = 0;
    n_empty = 0;
    word_len = 0;
    term_cnt = 0;
    bin_cnt = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[k])
      drive_item(directed[k].op, directed[k].lhs, directed[k].r1, directed[k].r2,
                 directed[k].sym, directed[k].typed, directed[k].count, directed[k].status);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 24) == 0) run_overflow();
      else run_grammar();
    end

    // longest word with one binary rule: the count is a catalan number, reduced mod the prime
    push(OP_CLEAR, '0, '0, '0, '0);
    push(OP_TERM, 5'd0, '0, '0, 8'h61);
    push(OP_TERM, 5'd1, '0, '0, 8'h61);
    push(OP_BINARY, 5'd0, 5'd0, 5'd0, '0);
    for (int k = 0; k <= MAX_WORD; k++) push(OP_APPEND, '0, '0, '0, 8'h61);
    push(OP_RUN, 5'd0, '0, '0, '0);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d transactions, %0d computes (%0d with a nonzero count)",
             items_sent, n_runs, n_nonzero);
    $display("capacity drops seen: %0d, empty-word computes: %0d, mismatches: %0d",
             n_full, n_empty, err_cnt);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
